// ===== rtl/mi3_pkg.sv =====
package mi3_pkg;

  // Word format
  localparam int W = 32;
  localparam int F = 16;

  // Derived widths
  localparam int PW  = 2 * W;          // element product
  localparam int CW  = 2 * W + 1;      // cofactor
  localparam int LW  = W + 1;          // low slice of a cofactor for the det multiply
  localparam int PLW = W + LW + 1;     // element times low slice
  localparam int TW  = 3 * W + 1;      // one det term
  localparam int DTW = 3 * W + 3;      // det sum
  localparam int DMW = 3 * W + 2;      // det magnitude
  localparam int AMW = 2 * W;          // cofactor magnitude
  localparam int NW  = AMW + 2 * F;    // dividend magnitude
  localparam int RW  = DMW + W;        // partial remainder
  localparam int NEL = 9;

  localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] LIM_NEG = {1'b1, {(W-1){1'b0}}};

  typedef logic [3:0] idx_t;

  // Adjugate term i = m[P]*m[Q] - m[R]*m[S], elements in row-major order
  localparam idx_t COF_P [NEL] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd3, 4'd3, 4'd6, 4'd0};
  localparam idx_t COF_Q [NEL] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd2, 4'd7, 4'd1, 4'd4};
  localparam idx_t COF_R [NEL] = '{4'd7, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd6, 4'd0, 4'd3};
  localparam idx_t COF_S [NEL] = '{4'd5, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd4, 4'd7, 4'd1};

  // Determinant side info carried alongside the dividers
  typedef struct packed {
    logic         sing;
    logic         dclip;
    logic [W-1:0] detw;
  } side_t;

endpackage

// ===== rtl/mi3_div_lane.sv =====
module mi3_div_lane (
  input  logic                   clk,
  input  logic                   en,
  input  logic [mi3_pkg::NW-1:0] num,
  input  logic [mi3_pkg::DMW-1:0] den,
  input  logic                   neg,
  output logic [mi3_pkg::W-1:0]  res,
  output logic                   clip
);
  import mi3_pkg::*;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [DMW-1:0] den;
    logic [W-1:0]   quo;
    logic           over;
    logic           neg;
  } dstage_t;

  dstage_t st_in;
  dstage_t st [1:W];

  // Flag quotients that cannot fit before the first step
  always_comb begin
    st_in.rem  = RW'(num);
    st_in.den  = den;
    st_in.quo  = '0;
    st_in.over = RW'(num) >= (RW'(den) << W);
    st_in.neg  = neg;
  end

  // One restoring step per stage, most significant quotient bit first
  for (genvar k = 0; k < W; k++) begin : g_step
    localparam int B = W - 1 - k;
    dstage_t        cur;
    dstage_t        nxt;
    logic [RW-1:0]  dsh;
    logic           take;

    if (k == 0) begin : g_first
      assign cur = st_in;
    end else begin : g_next
      assign cur = st[k];
    end

    assign dsh  = RW'(cur.den) << B;
    assign take = !cur.over && (cur.rem >= dsh);

    // Subtract the shifted divisor and set the quotient bit when it fits
    always_comb begin
      nxt = cur;
      if (take) begin
        nxt.rem    = cur.rem - dsh;
        nxt.quo[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  // Clip to the word range and apply the sign
  logic [W-1:0] lim;
  logic [W-1:0] val;

  always_comb begin
    lim  = st[W].neg ? LIM_NEG : LIM_POS;
    clip = st[W].over || (st[W].quo > lim);
    val  = clip ? lim : st[W].quo;
    res  = st[W].neg ? (~val + W'(1)) : val;
  end

endmodule

// ===== rtl/matrix3_inverse.sv =====
// 3x3 matrix inverse by the adjugate, signed fixed point (Q16.16 words). One matrix
// enters per clock unless mat_stall is high, and its result passes through these stages in order:
// one multiply stage, one cofactor stage, three stages that build the determinant,
// one stage that takes magnitudes, one stage per quotient bit in each of nine
// restoring dividers, and an output register. Every inverse element is truncated
// toward zero and clipped to the word range; det_out is the determinant truncated
// to Q16.16 and clipped. A zero determinant raises singular and zeroes all values.
// When the result is stalled the whole pipeline holds and mat_stall is raised.
module matrix3_inverse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          mat_valid,
  output logic                          mat_stall,
  input  logic signed [mi3_pkg::W-1:0]  a11,
  input  logic signed [mi3_pkg::W-1:0]  a12,
  input  logic signed [mi3_pkg::W-1:0]  a13,
  input  logic signed [mi3_pkg::W-1:0]  a21,
  input  logic signed [mi3_pkg::W-1:0]  a22,
  input  logic signed [mi3_pkg::W-1:0]  a23,
  input  logic signed [mi3_pkg::W-1:0]  a31,
  input  logic signed [mi3_pkg::W-1:0]  a32,
  input  logic signed [mi3_pkg::W-1:0]  a33,
  output logic                          inv_valid,
  input  logic                          inv_stall,
  output logic signed [mi3_pkg::W-1:0]  inv11,
  output logic signed [mi3_pkg::W-1:0]  inv12,
  output logic signed [mi3_pkg::W-1:0]  inv13,
  output logic signed [mi3_pkg::W-1:0]  inv21,
  output logic signed [mi3_pkg::W-1:0]  inv22,
  output logic signed [mi3_pkg::W-1:0]  inv23,
  output logic signed [mi3_pkg::W-1:0]  inv31,
  output logic signed [mi3_pkg::W-1:0]  inv32,
  output logic signed [mi3_pkg::W-1:0]  inv33,
  output logic signed [mi3_pkg::W-1:0]  det_out,
  output logic                          singular,
  output logic                          saturated
);
  import mi3_pkg::*;

  localparam int NSTG = W + 7;

  logic                en;
  logic [NSTG-1:0]     vld;
  logic signed [W-1:0] m [NEL];

  assign m[0] = a11;
  assign m[1] = a12;
  assign m[2] = a13;
  assign m[3] = a21;
  assign m[4] = a22;
  assign m[5] = a23;
  assign m[6] = a31;
  assign m[7] = a32;
  assign m[8] = a33;

  // Hold everything while the result waits
  assign en        = !(vld[NSTG-1] && inv_stall);
  assign mat_stall = !en;
  assign inv_valid = vld[NSTG-1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTG-2:0], mat_valid};
    end
  end

  // Stage 1: element products
  logic signed [PW-1:0] prod_p [NEL];
  logic signed [PW-1:0] prod_r [NEL];
  logic signed [W-1:0]  col_1 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        prod_p[i] <= m[COF_P[i]] * m[COF_Q[i]];
        prod_r[i] <= m[COF_R[i]] * m[COF_S[i]];
      end
      col_1[0] <= m[0];
      col_1[1] <= m[3];
      col_1[2] <= m[6];
    end
  end

  // Stage 2: adjugate terms
  logic signed [CW-1:0] cof2 [NEL];
  logic signed [W-1:0]  col_2 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        cof2[i] <= CW'(prod_p[i]) - CW'(prod_r[i]);
      end
      col_2 <= col_1;
    end
  end

  // Stage 3: first-column element times cofactor, split in two halves
  logic signed [CW-1:0]  cof3 [NEL];
  logic signed [PLW-1:0] plo3 [3];
  logic signed [PW-1:0]  phi3 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        plo3[j] <= col_2[j] * $signed({1'b0, cof2[j][LW-1:0]});
        phi3[j] <= col_2[j] * $signed(cof2[j][CW-1:LW]);
      end
      cof3 <= cof2;
    end
  end

  // Stage 4: join the halves
  logic signed [CW-1:0] cof4 [NEL];
  logic signed [TW-1:0] term4 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        term4[j] <= (TW'(phi3[j]) <<< LW) + TW'(plo3[j]);
      end
      cof4 <= cof3;
    end
  end

  // Stage 5: determinant
  logic signed [CW-1:0]  cof5 [NEL];
  logic signed [DTW-1:0] det5;

  always_ff @(posedge clk) begin
    if (en) begin
      det5 <= DTW'(term4[0]) + DTW'(term4[1]) + DTW'(term4[2]);
      cof5 <= cof4;
    end
  end

  // Stage 6: magnitudes, quotient signs and the det word
  logic             det_neg;
  logic [DTW-1:0]   det_abs;
  logic [DMW-1:0]   dmag;
  logic [DMW-1:0]   dq;
  logic [W-1:0]     dlim;
  logic [W-1:0]     dv;
  side_t            side_next;
  logic [CW-1:0]    cabs [NEL];
  logic [NW-1:0]    num6 [NEL];
  logic [NEL-1:0]   neg6;
  logic [DMW-1:0]   den6;
  side_t            sd [W+1];

  always_comb begin
    det_neg = det5[DTW-1];
    det_abs = det_neg ? DTW'(-det5) : DTW'(det5);
    dmag    = det_abs[DMW-1:0];
    dq      = dmag >> (2 * F);
    dlim    = det_neg ? LIM_NEG : LIM_POS;
    side_next.sing  = (det5 == '0);
    side_next.dclip = dq > DMW'(dlim);
    dv              = side_next.dclip ? dlim : dq[W-1:0];
    side_next.detw  = det_neg ? (~dv + W'(1)) : dv;
    for (int i = 0; i < NEL; i++) begin
      cabs[i] = cof5[i][CW-1] ? CW'(-cof5[i]) : CW'(cof5[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NEL; i++) begin
        num6[i] <= {cabs[i][AMW-1:0], {(2*F){1'b0}}};
        neg6[i] <= cof5[i][CW-1] ^ det_neg;
      end
      den6  <= dmag;
      sd[0] <= side_next;
      for (int k = 0; k < W; k++) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  // Dividers, one per inverse element
  logic [W-1:0]   lres [NEL];
  logic [NEL-1:0] lclip;

  for (genvar i = 0; i < NEL; i++) begin : g_lane
    mi3_div_lane u_lane (
      .clk  (clk),
      .en   (en),
      .num  (num6[i]),
      .den  (den6),
      .neg  (neg6[i]),
      .res  (lres[i]),
      .clip (lclip[i])
    );
  end

  // Output register; zero everything for a singular matrix
  logic [W-1:0] inv_r [NEL];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sd[W].sing) begin
        for (int i = 0; i < NEL; i++) begin
          inv_r[i] <= '0;
        end
        det_out   <= '0;
        singular  <= 1'b1;
        saturated <= 1'b0;
      end else begin
        inv_r     <= lres;
        det_out   <= sd[W].detw;
        singular  <= 1'b0;
        saturated <= sd[W].dclip | (|lclip);
      end
    end
  end

  assign inv11 = inv_r[0];
  assign inv12 = inv_r[1];
  assign inv13 = inv_r[2];
  assign inv21 = inv_r[3];
  assign inv22 = inv_r[4];
  assign inv23 = inv_r[5];
  assign inv31 = inv_r[6];
  assign inv32 = inv_r[7];
  assign inv33 = inv_r[8];

endmodule

// ===== rtl/mi3_checker.sv =====
module mi3_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         mat_stall,
  input logic                         inv_valid,
  input logic                         inv_stall,
  input logic signed [mi3_pkg::W-1:0] inv11,
  input logic signed [mi3_pkg::W-1:0] inv12,
  input logic signed [mi3_pkg::W-1:0] inv13,
  input logic signed [mi3_pkg::W-1:0] inv21,
  input logic signed [mi3_pkg::W-1:0] inv22,
  input logic signed [mi3_pkg::W-1:0] inv23,
  input logic signed [mi3_pkg::W-1:0] inv31,
  input logic signed [mi3_pkg::W-1:0] inv32,
  input logic signed [mi3_pkg::W-1:0] inv33,
  input logic signed [mi3_pkg::W-1:0] det_out,
  input logic                         singular,
  input logic                         saturated
);

  // Input is held back only by a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    mat_stall |-> (inv_valid && inv_stall))
    else $error("input stalled without a waiting result");

  // A singular request reports all zeros and no clipping
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (inv_valid && singular) |-> (det_out == '0 && !saturated &&
      inv11 == '0 && inv12 == '0 && inv13 == '0 &&
      inv21 == '0 && inv22 == '0 && inv23 == '0 &&
      inv31 == '0 && inv32 == '0 && inv33 == '0))
    else $error("singular result with nonzero outputs");

  // Nothing leaves right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !inv_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (inv_valid && inv_stall) |=> (inv_valid && $stable(inv11) && $stable(inv33) &&
      $stable(det_out) && $stable(singular) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

bind matrix3_inverse mi3_checker u_mi3_checker (.*);

// ===== verif/tb_matrix3_inverse.sv =====
`default_nettype none

module tb_matrix3_inverse;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = 10;            // nine inverse elements plus det_out
  localparam int STALL_LIMIT = 4000; // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_REQUESTS = 750;
  localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
  localparam logic signed [31:0] MAX_W = 32'sh7fff_ffff;
  localparam logic signed [31:0] MIN_W = 32'sh8000_0000;

  typedef logic signed [255:0] wide_t;
  typedef logic signed [31:0] word_t;
  typedef word_t mat_t [9];

  typedef struct {
    word_t v [NF];
    logic  sing;
    logic  sat;
  } inv_res_t;

  typedef struct {
    mat_t     m;
    bit       typed;
    inv_res_t res;
  } vector_t;

  // cofactor i = e[P]*e[Q] - e[R]*e[S], row-major elements
  localparam int CP [9] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int CQ [9] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int CR [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int CS [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  logic  clk = 1'b0;
  logic  rst;
  logic  mat_valid;
  logic  mat_stall;
  word_t mat_in [9];
  logic  inv_valid;
  logic  inv_stall;
  word_t inv_out [NF];
  logic  singular;
  logic  saturated;

  inv_res_t expected_inverses [$];
  int       mismatches = 0;
  int       idle_cycles = 0;
  bit       calm = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  matrix3_inverse dut (
    .clk(clk), .rst(rst),
    .mat_valid(mat_valid), .mat_stall(mat_stall),
    .a11(mat_in[0]), .a12(mat_in[1]), .a13(mat_in[2]),
    .a21(mat_in[3]), .a22(mat_in[4]), .a23(mat_in[5]),
    .a31(mat_in[6]), .a32(mat_in[7]), .a33(mat_in[8]),
    .inv_valid(inv_valid), .inv_stall(inv_stall),
    .inv11(inv_out[0]), .inv12(inv_out[1]), .inv13(inv_out[2]),
    .inv21(inv_out[3]), .inv22(inv_out[4]), .inv23(inv_out[5]),
    .inv31(inv_out[6]), .inv32(inv_out[7]), .inv33(inv_out[8]),
    .det_out(inv_out[9]), .singular(singular), .saturated(saturated)
  );

  // clamp an exact value to the word range, flag clipping
  function automatic word_t clamp_word(input wide_t x, inout logic clip);
    if (x > wide_t'(MAX_W)) begin
      clip = 1'b1;
      return MAX_W;
    end
    if (x < wide_t'(MIN_W)) begin
      clip = 1'b1;
      return MIN_W;
    end
    return x[31:0];
  endfunction

  // exact adjugate inverse with truncating divides
  function automatic inv_res_t predict_inverse(input mat_t m);
    wide_t    e [9];
    wide_t    adj [9];
    wide_t    det;
    inv_res_t r;
    logic     clip;
    clip = 1'b0;
    for (int i = 0; i < 9; i++) e[i] = m[i];
    for (int i = 0; i < 9; i++) adj[i] = e[CP[i]] * e[CQ[i]] - e[CR[i]] * e[CS[i]];
    det = e[0] * adj[0] - e[3] * (e[8] * e[1] - e[7] * e[2])
        + e[6] * (e[5] * e[1] - e[4] * e[2]);
    r.sing = (det == 0);
    if (r.sing) begin
      for (int i = 0; i < NF; i++) r.v[i] = '0;
      r.sat = 1'b0;
      return r;
    end
    for (int i = 0; i < 9; i++) r.v[i] = clamp_word((adj[i] <<< 32) / det, clip);
    r.v[9] = clamp_word(det / (wide_t'(1) <<< 32), clip);
    r.sat = clip;
    return r;
  endfunction

  function automatic inv_res_t diag_result(input word_t d, input word_t dg, input logic s);
    inv_res_t r;
    for (int i = 0; i < NF; i++) r.v[i] = '0;
    r.v[0] = d;
    r.v[4] = d;
    r.v[8] = d;
    r.v[9] = dg;
    r.sing = 1'b0;
    r.sat = s;
    return r;
  endfunction

  function automatic inv_res_t singular_result();
    inv_res_t r;
    for (int i = 0; i < NF; i++) r.v[i] = '0;
    r.sing = 1'b1;
    r.sat = 1'b0;
    return r;
  endfunction

  function automatic word_t rand_word();
    return word_t'($urandom);
  endfunction

  // small Q16.16 value, a few units either side of zero
  function automatic word_t rand_small();
    return word_t'($urandom_range(32'h0008_0000)) - word_t'(32'h0004_0000);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (calm || p < 60) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // build a random matrix of one of several shapes
  function automatic mat_t rand_matrix();
    mat_t m;
    int   shape;
    shape = $urandom_range(5);
    case (shape)
      0: begin
        for (int i = 0; i < 9; i++) m[i] = rand_word();
      end
      1, 2: begin
        for (int i = 0; i < 9; i++) m[i] = rand_small();
      end
      3: begin
        // third row a sum of the first two: singular or nearly so
        for (int i = 0; i < 6; i++) m[i] = rand_small();
        for (int i = 0; i < 3; i++) m[6 + i] = m[i] + m[3 + i] + word_t'($urandom_range(2));
      end
      4: begin
        // sparse, mostly diagonal, with extremes
        for (int i = 0; i < 9; i++) m[i] = '0;
        for (int i = 0; i < 9; i += 4) begin
          case ($urandom_range(3))
            0: m[i] = MAX_W;
            1: m[i] = MIN_W;
            2: m[i] = word_t'($urandom_range(255)) - 128;
            default: m[i] = rand_small();
          endcase
        end
        m[$urandom_range(8)] = rand_word();
      end
      default: begin
        // scaled identity plus small noise
        for (int i = 0; i < 9; i++) m[i] = word_t'($urandom_range(4095)) - 2048;
        for (int i = 0; i < 9; i += 4) m[i] += word_t'($urandom_range(8, 1)) <<< 15;
      end
    endcase
    return m;
  endfunction

  // send one request, record its expectation, then drain if asked or idle for a random gap that may be zero
  task automatic send_matrix(input mat_t m, input bit typed, input inv_res_t res,
                             input bit drain);
    int g;
    for (int i = 0; i < 9; i++) mat_in[i] <= m[i];
    mat_valid <= 1'b1;
    @(posedge clk);
    while (mat_stall) @(posedge clk);
    expected_inverses.push_back(typed ? res : predict_inverse(m));
    g = pick_gap();
    if (drain) begin
      mat_valid <= 1'b0;
      @(posedge clk);
      while (expected_inverses.size() > 0) @(posedge clk);
    end else if (g > 0) begin
      mat_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // alternate calm stretches with randomly idling ones
  always @(posedge clk) begin
    if ($urandom_range(199) == 0) calm <= ~calm;
  end

  // receiver stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      inv_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      inv_stall <= 1'b1;
    end else if (!calm && $urandom_range(99) < 25) begin
      stall_left <= ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(60, 10);
      inv_stall <= 1'b1;
    end else begin
      inv_stall <= 1'b0;
    end
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    inv_res_t exp_r;
    bit       bad;
    if (!rst && inv_valid && !inv_stall) begin
      if (expected_inverses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result, nothing pending");
      end else begin
        exp_r = expected_inverses.pop_front();
        bad = (singular !== exp_r.sing) || (saturated !== exp_r.sat);
        for (int i = 0; i < NF; i++) if (inv_out[i] !== exp_r.v[i]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            for (int i = 0; i < NF; i++)
              if (inv_out[i] !== exp_r.v[i])
                $display("field %0d: expected %h got %h", i, exp_r.v[i], inv_out[i]);
            $display("singular exp %b got %b, saturated exp %b got %b",
                     exp_r.sing, singular, exp_r.sat, saturated);
          end
        end
      end
    end
  end

  // watchdog: abort when no handshake happens for too long
  always @(posedge clk) begin
    if ((mat_valid && !mat_stall) || (inv_valid && !inv_stall) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_matrix3_inverse: done, errors");
      $finish;
    end
  end

  vector_t vectors [$];

  initial begin
    vector_t  vec;
    mat_t     m;
    inv_res_t none;
    rst = 1'b1;
    mat_valid = 1'b0;
    for (int i = 0; i < 9; i++) mat_in[i] = '0;
    none = singular_result();

    // directed table: typed results where obvious, the rest predicted
    for (int i = 0; i < 9; i++) m[i] = '0;
    vec.m = m; vec.typed = 1; vec.res = singular_result(); vectors.push_back(vec);
    m[0] = ONE_Q; m[4] = ONE_Q; m[8] = ONE_Q;
    vec.m = m; vec.res = diag_result(ONE_Q, ONE_Q, 1'b0); vectors.push_back(vec);
    m[0] = 2 * ONE_Q; m[4] = 2 * ONE_Q; m[8] = 2 * ONE_Q;
    vec.m = m; vec.res = diag_result(ONE_Q / 2, 8 * ONE_Q, 1'b0); vectors.push_back(vec);
    // tiny nonzero determinant: inverse clips, det_out reads zero
    m[0] = 1; m[4] = 1; m[8] = 1;
    vec.m = m; vec.res = diag_result(MAX_W, '0, 1'b1); vectors.push_back(vec);
    for (int i = 0; i < 9; i++) m[i] = MAX_W;
    vec.m = m; vec.res = singular_result(); vectors.push_back(vec);
    for (int i = 0; i < 9; i++) m[i] = MIN_W;
    vec.m = m; vec.res = singular_result(); vectors.push_back(vec);
    vec.typed = 0; vec.res = none;
    for (int i = 0; i < 9; i++) m[i] = '0;
    m[0] = MIN_W; m[4] = MIN_W; m[8] = MIN_W;
    vec.m = m; vectors.push_back(vec);
    m[0] = MAX_W; m[4] = MAX_W; m[8] = MAX_W;
    vec.m = m; vectors.push_back(vec);
    m[0] = MAX_W; m[4] = MIN_W; m[8] = -ONE_Q;
    vec.m = m; vectors.push_back(vec);
    m = '{ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0, ONE_Q, 4 * ONE_Q, 5 * ONE_Q, 6 * ONE_Q, 0};
    vec.m = m; vectors.push_back(vec);
    m = '{-ONE_Q, 32'sh0000_8000, 7, 3 * ONE_Q, -5, ONE_Q, 0, -ONE_Q, 32'sh0001_8000};
    vec.m = m; vectors.push_back(vec);
    m = '{0, ONE_Q, 0, 0, 0, ONE_Q, ONE_Q, 0, 0};
    vec.m = m; vectors.push_back(vec);
    m = '{32'sh5555_5555, 32'shaaaa_aaaa, -1, 1, 32'sh5555_5555, 32'shaaaa_aaaa,
          32'shaaaa_aaaa, -1, 32'sh5555_5555};
    vec.m = m; vectors.push_back(vec);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[k])
      send_matrix(vectors[k].m, vectors[k].typed, vectors[k].res,
                  k == vectors.size() - 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++)
      send_matrix(rand_matrix(), 1'b0, none, n == RANDOM_REQUESTS / 2);

    // drain and let the pipeline settle
    mat_valid <= 1'b0;
    while (expected_inverses.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb_matrix3_inverse: done, clean");
    else
      $display("tb_matrix3_inverse: done, errors");
    $finish;
  end
endmodule

`default_nettype wire

// ===== files.f =====
rtl/mi3_pkg.sv
rtl/mi3_div_lane.sv
rtl/matrix3_inverse.sv
rtl/mi3_checker.sv
verif/tb_matrix3_inverse.sv
